// File: src/ecbp_pkg.sv
package ecbp_pkg;

	// Width and reset value of the configuration register, and the default length width.
	localparam int MaxBlocksW     = 16;
	localparam logic [MaxBlocksW-1:0] MaxBlocksReset = 16'd256;
	localparam int DefLengthBits  = 32;

	// Result kinds.
	localparam logic [1:0] KIND_BLOCK  = 2'd0;
	localparam logic [1:0] KIND_TIME   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_TAG   = 3'd1;
	localparam logic [2:0] ST_BAD_VINT  = 3'd2;
	localparam logic [2:0] ST_TRUNC     = 3'd3;
	localparam logic [2:0] ST_UNKNOWN   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_INT_SIZE  = 3'd6;
	localparam logic [2:0] ST_LEN_ERR   = 3'd7;

	// Element tags.
	localparam logic [63:0] TAG_CLUSTER  = 64'h1F43B675;
	localparam logic [63:0] TAG_TIMECODE = 64'hE7;
	localparam logic [63:0] TAG_SBLOCK   = 64'hA3;
	localparam logic [63:0] TAG_SILENT   = 64'h5854;
	localparam logic [63:0] TAG_POSITION = 64'hA7;
	localparam logic [63:0] TAG_PREVSIZE = 64'hAB;
	localparam logic [63:0] TAG_BGROUP   = 64'hA0;

	// Register index of max_blocks.
	localparam logic [0:0] REG_MAX_BLOCKS = 1'b0;

	// One result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] block_index;
		logic [31:0] track_number;
		logic [15:0] block_timecode;
		logic [7:0]  block_flags;
		logic [31:0] payload_offset;
		logic [31:0] payload_size;
		logic [63:0] cluster_time;
		logic [2:0]  status;
		logic        last_of_run;
	} res_t;

	// Results of one byte, handed to the output queue.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

	// Outcome of one vint or raw field byte.
	typedef struct packed {
		logic        bad;
		logic        done;
		logic [63:0] acc;
		logic [3:0]  left;
	} fld_t;

	// One byte of a variable-length integer.
	function automatic fld_t vint_step(logic [63:0] acc, logic [3:0] left,
		logic [7:0] b, logic keep);
		fld_t v;
		logic [3:0] n;
		logic found;
		v.bad = 1'b0;
		v.acc = acc;
		v.left = left;
		n = 4'd8;
		found = 1'b0;
		if (left == 4'd0) begin
			if (b == 8'd0) begin
				v.bad = 1'b1;
			end else begin
				for (int i = 0; i < 8; i++) begin
					if (!found && b[7-i]) begin
						n = 4'(i + 1);
						found = 1'b1;
					end
				end
				v.acc = keep ? {56'd0, b} : {56'd0, b & (8'hFF >> n)};
				v.left = n - 4'd1;
			end
		end else begin
			v.acc = {acc[55:0], b};
			v.left = left - 4'd1;
		end
		v.done = !v.bad && (v.left == 4'd0);
		return v;
	endfunction

	// One byte of a fixed-size big-endian field.
	function automatic fld_t raw_step(logic [63:0] acc, logic [3:0] left, logic [7:0] b);
		fld_t v;
		v.bad = 1'b0;
		v.acc = {acc[55:0], b};
		v.left = (left != 4'd0) ? left - 4'd1 : 4'd0;
		v.done = (v.left == 4'd0);
		return v;
	endfunction

endpackage

// File: src/ecbp_core.sv
module ecbp_core import ecbp_pkg::*; #(
	parameter int LENGTH_BITS = DefLengthBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_buffer,
	input  logic [MaxBlocksW-1:0] max_blocks,
	output push_t                 push
);

	localparam logic [3:0] PH_CTAG      = 4'd0;
	localparam logic [3:0] PH_CSIZE     = 4'd1;
	localparam logic [3:0] PH_CHILD_TAG = 4'd2;
	localparam logic [3:0] PH_TC_SIZE   = 4'd3;
	localparam logic [3:0] PH_TC_DATA   = 4'd4;
	localparam logic [3:0] PH_SB_SIZE   = 4'd5;
	localparam logic [3:0] PH_SB_TRACK  = 4'd6;
	localparam logic [3:0] PH_SB_TIME   = 4'd7;
	localparam logic [3:0] PH_SB_FLAGS  = 4'd8;
	localparam logic [3:0] PH_SKIP_SIZE = 4'd9;
	localparam logic [3:0] PH_SKIP_BODY = 4'd10;
	localparam logic [3:0] PH_INT_SIZE  = 4'd11;
	localparam logic [3:0] PH_INT_DATA  = 4'd12;
	localparam logic [3:0] PH_DONE      = 4'd13;

	logic [3:0]             phase_q, phase_d;
	logic [63:0]            acc_q, acc_d;
	logic [3:0]             left_q, left_d;
	logic [LENGTH_BITS-1:0] cbl_q, cbl_d;
	logic [LENGTH_BITS-1:0] chbl_q, chbl_d;
	logic [31:0]            pos_q, pos_d;
	logic [15:0]            bcnt_q, bcnt_d;
	logic [31:0]            track_q, track_d;
	logic [15:0]            btime_q, btime_d;
	logic                   fin_q, fin_d;

	// Per-byte decode: next state and the results of this byte.
	always_comb begin
		fld_t  f;
		logic  fin_now;
		logic  has_data;
		res_t  dres;
		res_t  sres;
		logic [2:0] scode;
		logic  over;
		logic  tocheck;

		phase_d = phase_q; acc_d = acc_q; left_d = left_q;
		cbl_d = cbl_q; chbl_d = chbl_q; pos_d = pos_q; bcnt_d = bcnt_q;
		track_d = track_q; btime_d = btime_q; fin_d = fin_q;
		f = '0;
		fin_now = 1'b0;
		has_data = 1'b0;
		dres = '0;
		sres = '0;
		scode = ST_OK;
		over = 1'b0;
		tocheck = 1'b0;

		if (!fin_q) begin
			case (phase_q)
				PH_CTAG: begin
					f = vint_step(acc_q, left_q, data_byte, 1'b1);
					acc_d = f.acc; left_d = f.left;
					if (f.bad) begin
						fin_now = 1'b1; scode = ST_BAD_VINT;
					end else if (f.done) begin
						if (f.acc != TAG_CLUSTER) begin
							fin_now = 1'b1; scode = ST_BAD_TAG;
						end else begin
							phase_d = PH_CSIZE;
						end
					end
				end
				PH_CSIZE: begin
					f = vint_step(acc_q, left_q, data_byte, 1'b0);
					acc_d = f.acc; left_d = f.left;
					over = (f.acc >> LENGTH_BITS) != 64'd0;
					if (f.bad) begin
						fin_now = 1'b1; scode = ST_BAD_VINT;
					end else if (f.done) begin
						if (over) begin
							fin_now = 1'b1; scode = ST_LEN_ERR;
						end else if (f.acc == 64'd0) begin
							fin_now = 1'b1; scode = ST_OK;
						end else begin
							cbl_d = f.acc[LENGTH_BITS-1:0];
							phase_d = PH_CHILD_TAG;
						end
					end
				end
				PH_DONE: begin
				end
				default: begin
					tocheck = 1'b1;
					if (cbl_q != '0)
						cbl_d = cbl_q - 1'b1;
					// Child element bytes.
					case (phase_q)
						PH_CHILD_TAG: begin
							f = vint_step(acc_q, left_q, data_byte, 1'b1);
							acc_d = f.acc; left_d = f.left;
							if (f.bad) begin
								fin_now = 1'b1; scode = ST_BAD_VINT;
							end else if (f.done) begin
								if (f.acc == TAG_TIMECODE) begin
									phase_d = PH_TC_SIZE;
								end else if (f.acc == TAG_SBLOCK) begin
									if (bcnt_q >= max_blocks) begin
										fin_now = 1'b1; scode = ST_FULL;
									end else begin
										phase_d = PH_SB_SIZE;
									end
								end else if (f.acc inside {TAG_SILENT, TAG_BGROUP}) begin
									phase_d = PH_SKIP_SIZE;
								end else if (f.acc inside {TAG_POSITION, TAG_PREVSIZE}) begin
									phase_d = PH_INT_SIZE;
								end else begin
									fin_now = 1'b1; scode = ST_UNKNOWN;
								end
							end
						end
						PH_TC_SIZE, PH_INT_SIZE: begin
							f = vint_step(acc_q, left_q, data_byte, 1'b0);
							acc_d = f.acc; left_d = f.left;
							if (f.bad) begin
								fin_now = 1'b1; scode = ST_BAD_VINT;
							end else if (f.done) begin
								if (!(f.acc inside {[64'd1:64'd8]})) begin
									fin_now = 1'b1; scode = ST_INT_SIZE;
								end else begin
									acc_d = '0;
									left_d = f.acc[3:0];
									phase_d = (phase_q == PH_TC_SIZE) ? PH_TC_DATA
										: PH_INT_DATA;
								end
							end
						end
						PH_TC_DATA, PH_INT_DATA: begin
							f = raw_step(acc_q, left_q, data_byte);
							acc_d = f.acc; left_d = f.left;
							if (f.done) begin
								phase_d = PH_CHILD_TAG;
								if (phase_q == PH_TC_DATA) begin
									has_data = 1'b1;
									dres.kind = KIND_TIME;
									dres.cluster_time = f.acc;
								end
							end
						end
						PH_SB_SIZE, PH_SKIP_SIZE: begin
							f = vint_step(acc_q, left_q, data_byte, 1'b0);
							acc_d = f.acc; left_d = f.left;
							over = (f.acc >> LENGTH_BITS) != 64'd0;
							if (f.bad) begin
								fin_now = 1'b1; scode = ST_BAD_VINT;
							end else if (f.done) begin
								if (over) begin
									fin_now = 1'b1; scode = ST_LEN_ERR;
								end else if (f.acc[LENGTH_BITS-1:0] > cbl_d) begin
									fin_now = 1'b1; scode = ST_TRUNC;
								end else begin
									chbl_d = f.acc[LENGTH_BITS-1:0];
									if (phase_q == PH_SKIP_SIZE) begin
										phase_d = (f.acc != 64'd0) ? PH_SKIP_BODY
											: PH_CHILD_TAG;
									end else if (f.acc == 64'd0) begin
										fin_now = 1'b1; scode = ST_LEN_ERR;
									end else begin
										phase_d = PH_SB_TRACK;
									end
								end
							end
						end
						PH_SB_TRACK: begin
							chbl_d = chbl_q - 1'b1;
							f = vint_step(acc_q, left_q, data_byte, 1'b0);
							acc_d = f.acc; left_d = f.left;
							if (f.bad) begin
								fin_now = 1'b1; scode = ST_BAD_VINT;
							end else begin
								if (f.done) begin
									track_d = f.acc[31:0];
									acc_d = '0;
									left_d = 4'd2;
									phase_d = PH_SB_TIME;
								end
								if (chbl_d == '0) begin
									fin_now = 1'b1; scode = ST_LEN_ERR;
								end
							end
						end
						PH_SB_TIME: begin
							chbl_d = chbl_q - 1'b1;
							f = raw_step(acc_q, left_q, data_byte);
							acc_d = f.acc; left_d = f.left;
							if (f.done) begin
								btime_d = f.acc[15:0];
								acc_d = '0;
								left_d = 4'd1;
								phase_d = PH_SB_FLAGS;
							end
							if (chbl_d == '0) begin
								fin_now = 1'b1; scode = ST_LEN_ERR;
							end
						end
						PH_SB_FLAGS: begin
							chbl_d = chbl_q - 1'b1;
							f = raw_step(acc_q, left_q, data_byte);
							acc_d = f.acc; left_d = f.left;
							has_data = 1'b1;
							dres.kind = KIND_BLOCK;
							dres.block_index = bcnt_q;
							dres.track_number = track_q;
							dres.block_timecode = btime_q;
							dres.block_flags = f.acc[7:0];
							dres.payload_offset = pos_q + 32'd1;
							dres.payload_size = 32'(64'(chbl_d));
							bcnt_d = bcnt_q + 16'd1;
							phase_d = (chbl_d != '0) ? PH_SKIP_BODY : PH_CHILD_TAG;
						end
						PH_SKIP_BODY: begin
							if (chbl_q != '0)
								chbl_d = chbl_q - 1'b1;
							if (chbl_d == '0)
								phase_d = PH_CHILD_TAG;
						end
						default: begin
						end
					endcase
				end
			endcase
			// End of the cluster body.
			if (tocheck && !fin_now && cbl_d == '0) begin
				fin_now = 1'b1;
				scode = (phase_d == PH_CHILD_TAG && left_d == 4'd0) ? ST_OK : ST_TRUNC;
			end
		end

		pos_d = pos_q + 32'd1;
		// Buffer ends before the parse is complete.
		if (end_of_buffer && !fin_q && !fin_now) begin
			fin_now = 1'b1;
			scode = ST_TRUNC;
		end
		if (fin_now) begin
			fin_d = 1'b1;
			phase_d = PH_DONE;
		end

		sres.kind = KIND_STATUS;
		sres.status = scode;
		sres.last_of_run = 1'b1;

		// Return to reset after the last byte of a buffer.
		if (end_of_buffer) begin
			phase_d = PH_CTAG; acc_d = '0; left_d = '0; cbl_d = '0; chbl_d = '0;
			pos_d = '0; bcnt_d = '0; track_d = '0; btime_d = '0; fin_d = 1'b0;
		end

		push.r1 = sres;
		if (has_data) begin
			dres.last_of_run = !fin_now;
			push.r0 = dres;
			push.count = fin_now ? 2'd2 : 2'd1;
		end else begin
			push.r0 = sres;
			push.count = fin_now ? 2'd1 : 2'd0;
		end
	end

	// Parser state, updated on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CTAG;
			acc_q <= '0;
			left_q <= '0;
			cbl_q <= '0;
			chbl_q <= '0;
			pos_q <= '0;
			bcnt_q <= '0;
			track_q <= '0;
			btime_q <= '0;
			fin_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			left_q <= left_d;
			cbl_q <= cbl_d;
			chbl_q <= chbl_d;
			pos_q <= pos_d;
			bcnt_q <= bcnt_d;
			track_q <= track_d;
			btime_q <= btime_d;
			fin_q <= fin_d;
		end
	end

endmodule

// File: src/ecbp_outq.sv
module ecbp_outq import ecbp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_en,
	input  push_t push,
	output logic  full,
	output logic  out_valid,
	input  logic  out_stall,
	output res_t  head
);

	res_t       slot_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic [1:0] n_in;
	logic       pop;

	// Room for two results is needed before a byte is taken.
	assign full = cnt_q > 3'd2;
	assign out_valid = cnt_q != 3'd0;
	assign head = slot_q[rd_q];
	assign pop = out_valid && !out_stall;
	assign n_in = push_en ? push.count : 2'd0;

	// Result storage.
	always_ff @(posedge clk) begin
		if (n_in != 2'd0)
			slot_q[wr_q] <= push.r0;
		if (n_in == 2'd2)
			slot_q[wr_q + 2'd1] <= push.r1;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + n_in;
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, n_in} - {2'd0, pop};
		end
	end

endmodule

// File: src/ebml_cluster_block_parser.sv
// Each byte transfer is parsed in the cycle it is taken; its results enter the
// registered output queue at that edge.
// Throughput is one byte per cycle; the input stalls only while the four-entry
// result queue has fewer than two free entries.
// Reset is asynchronous and active low; it restores the parser to the cluster
// tag phase and max_blocks to 256.
module ebml_cluster_block_parser import ecbp_pkg::*; #(
	parameter int LENGTH_BITS = DefLengthBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] block_index,
	output logic [31:0] track_number,
	output logic [15:0] block_timecode,
	output logic [7:0]  block_flags,
	output logic [31:0] payload_offset,
	output logic [31:0] payload_size,
	output logic [63:0] cluster_time,
	output logic [2:0]  status,
	output logic        last_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [MaxBlocksW-1:0] max_blocks_q;
	logic                  accept;
	logic                  full;
	push_t                 push;
	res_t                  head;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_BLOCKS && paddr[1:0] == 2'd0)
		? {16'd0, max_blocks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_blocks_q <= MaxBlocksReset;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_BLOCKS &&
			paddr[1:0] == 2'd0) begin
			max_blocks_q <= pwdata[MaxBlocksW-1:0];
		end
	end

	assign in_stall = full;
	assign accept = in_valid && !full;

	ecbp_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.max_blocks    (max_blocks_q),
		.push          (push)
	);

	ecbp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (accept),
		.push      (push),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// Result fields.
	assign kind           = head.kind;
	assign block_index    = head.block_index;
	assign track_number   = head.track_number;
	assign block_timecode = head.block_timecode;
	assign block_flags    = head.block_flags;
	assign payload_offset = head.payload_offset;
	assign payload_size   = head.payload_size;
	assign cluster_time   = head.cluster_time;
	assign status         = head.status;
	assign last_of_run    = head.last_of_run;

endmodule

// File: sim/tb_ebml_cluster_block_parser.sv
`timescale 1ns / 1ps

module tb_ebml_cluster_block_parser;
	import ecbp_pkg::*;

	localparam int CycleLimit = 800000;
	localparam logic [63:0] LenLimit = 64'hFFFF_FFFF;

	// Parser phases of the prediction.
	typedef enum int {
		S_TAG, S_SIZE, S_CHILD, S_TC_LEN, S_TC_VAL, S_SB_LEN, S_SB_TRACK, S_SB_TIME,
		S_SB_FLAGS, S_SKIP_LEN, S_SKIP, S_INT_LEN, S_INT_VAL, S_DONE
	} phase_t;

	// Cluster parse prediction and queue of expected results.
	class ClusterScoreboard;
		res_t expected_results[$];
		res_t step_out[$];
		int errors;
		int bytes_taken;
		int results_seen;
		logic [15:0] block_limit;
		phase_t phase;
		logic [63:0] acc;
		int field_left;
		logic [63:0] cluster_left;
		logic [63:0] child_left;
		logic [31:0] position;
		logic [15:0] blocks;
		logic [31:0] held_track;
		logic [15:0] held_time;
		bit done;

		function new();
			block_limit = MaxBlocksReset;
			clear();
		endfunction

		function void clear();
			phase = S_TAG;
			acc = '0;
			field_left = 0;
			cluster_left = '0;
			child_left = '0;
			position = '0;
			blocks = '0;
			held_track = '0;
			held_time = '0;
			done = 0;
		endfunction

		function void emit(logic [1:0] k, logic [15:0] idx, logic [31:0] trk,
			logic [15:0] bt, logic [7:0] fl, logic [31:0] off, logic [31:0] sz,
			logic [63:0] ct, logic [2:0] st);
			res_t r;
			if (step_out.size() >= 2) return;
			r = '0;
			r.kind = k;
			r.block_index = idx;
			r.track_number = trk;
			r.block_timecode = bt;
			r.block_flags = fl;
			r.payload_offset = off;
			r.payload_size = sz;
			r.cluster_time = ct;
			r.status = st;
			step_out.push_back(r);
		endfunction

		function void finish_parse(logic [2:0] st);
			emit(KIND_STATUS, 0, 0, 0, 0, 0, 0, 0, st);
			done = 1;
			phase = S_DONE;
		endfunction

		// Variable-length integer byte: -1 malformed, 0 more to come, 1 complete.
		function int vint_byte(logic [7:0] b, bit keep);
			int n;
			if (field_left == 0) begin
				if (b == 0) return -1;
				n = 1;
				while (b[8-n] == 1'b0) n++;
				acc = keep ? {56'd0, b} : {56'd0, b & (8'hFF >> n)};
				field_left = n - 1;
			end else begin
				acc = {acc[55:0], b};
				field_left--;
			end
			return (field_left == 0) ? 1 : 0;
		endfunction

		function bit raw_byte(logic [7:0] b);
			acc = {acc[55:0], b};
			if (field_left > 0) field_left--;
			return field_left == 0;
		endfunction

		function void start_raw(int n, phase_t p);
			acc = '0;
			field_left = n;
			phase = p;
		endfunction

		function void child_byte(logic [7:0] b);
			int r;
			logic [63:0] v;
			case (phase)
				S_CHILD: begin
					r = vint_byte(b, 1);
					if (r < 0) finish_parse(ST_BAD_VINT);
					else if (r > 0) begin
						v = acc;
						if (v == TAG_TIMECODE) phase = S_TC_LEN;
						else if (v == TAG_SBLOCK) begin
							if (blocks >= block_limit) finish_parse(ST_FULL);
							else phase = S_SB_LEN;
						end else if (v inside {TAG_SILENT, TAG_BGROUP}) phase = S_SKIP_LEN;
						else if (v inside {TAG_POSITION, TAG_PREVSIZE}) phase = S_INT_LEN;
						else finish_parse(ST_UNKNOWN);
					end
				end
				S_TC_LEN, S_INT_LEN: begin
					r = vint_byte(b, 0);
					if (r < 0) finish_parse(ST_BAD_VINT);
					else if (r > 0) begin
						if (!(acc inside {[64'd1:64'd8]})) finish_parse(ST_INT_SIZE);
						else start_raw(int'(acc), (phase == S_TC_LEN) ? S_TC_VAL : S_INT_VAL);
					end
				end
				S_TC_VAL: begin
					if (raw_byte(b)) begin
						emit(KIND_TIME, 0, 0, 0, 0, 0, 0, acc, ST_OK);
						phase = S_CHILD;
					end
				end
				S_INT_VAL: begin
					if (raw_byte(b)) phase = S_CHILD;
				end
				S_SB_LEN, S_SKIP_LEN: begin
					r = vint_byte(b, 0);
					if (r < 0) finish_parse(ST_BAD_VINT);
					else if (r > 0) begin
						v = acc;
						if (v > LenLimit) finish_parse(ST_LEN_ERR);
						else if (v > cluster_left) finish_parse(ST_TRUNC);
						else begin
							child_left = v;
							if (phase == S_SKIP_LEN) phase = (v != 0) ? S_SKIP : S_CHILD;
							else if (v == 0) finish_parse(ST_LEN_ERR);
							else phase = S_SB_TRACK;
						end
					end
				end
				S_SB_TRACK, S_SB_TIME, S_SB_FLAGS: begin
					child_left--;
					if (phase == S_SB_FLAGS) begin
						void'(raw_byte(b));
						emit(KIND_BLOCK, blocks, held_track, held_time, acc[7:0],
							position + 32'd1, child_left[31:0], 0, ST_OK);
						blocks++;
						phase = (child_left != 0) ? S_SKIP : S_CHILD;
						return;
					end
					if (phase == S_SB_TRACK) begin
						r = vint_byte(b, 0);
						if (r < 0) begin
							finish_parse(ST_BAD_VINT);
							return;
						end
						if (r > 0) begin
							held_track = acc[31:0];
							start_raw(2, S_SB_TIME);
						end
					end else if (raw_byte(b)) begin
						held_time = acc[15:0];
						start_raw(1, S_SB_FLAGS);
					end
					if (child_left == 0) finish_parse(ST_LEN_ERR);
				end
				S_SKIP: begin
					if (child_left > 0) child_left--;
					if (child_left == 0) phase = S_CHILD;
				end
				default: ;
			endcase
		endfunction

		function void parse_byte(logic [7:0] b);
			int r;
			if (phase == S_TAG) begin
				r = vint_byte(b, 1);
				if (r < 0) finish_parse(ST_BAD_VINT);
				else if (r > 0) begin
					if (acc != TAG_CLUSTER) finish_parse(ST_BAD_TAG);
					else phase = S_SIZE;
				end
				return;
			end
			if (phase == S_SIZE) begin
				r = vint_byte(b, 0);
				if (r < 0) finish_parse(ST_BAD_VINT);
				else if (r > 0) begin
					if (acc > LenLimit) finish_parse(ST_LEN_ERR);
					else if (acc == 0) finish_parse(ST_OK);
					else begin
						cluster_left = acc;
						phase = S_CHILD;
					end
				end
				return;
			end
			if (phase == S_DONE) return;
			if (cluster_left > 0) cluster_left--;
			child_byte(b);
			if (!done && cluster_left == 0) begin
				if (phase == S_CHILD && field_left == 0) finish_parse(ST_OK);
				else finish_parse(ST_TRUNC);
			end
		endfunction

		// An accepted byte transfer: predict the results it causes.
		function void note_byte(logic [7:0] b, logic eob);
			step_out.delete();
			bytes_taken++;
			if (!done) parse_byte(b);
			position++;
			if (eob) begin
				if (!done) finish_parse(ST_TRUNC);
				clear();
			end
			if (step_out.size() > 0) step_out[step_out.size()-1].last_of_run = 1'b1;
			foreach (step_out[i]) expected_results.push_back(step_out[i]);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch at result %0d: %s got %0h expected %0h",
				results_seen, what, got, want);
		endtask

		// An accepted result transfer: compare it with the oldest expectation.
		task check_result(res_t got);
			res_t want;
			results_seen++;
			if (expected_results.size() == 0) begin
				report("unexpected result, kind", got.kind, 0);
				return;
			end
			want = expected_results.pop_front();
			if (got.kind != want.kind) report("kind", got.kind, want.kind);
			if (got.block_index != want.block_index)
				report("block_index", got.block_index, want.block_index);
			if (got.track_number != want.track_number)
				report("track_number", got.track_number, want.track_number);
			if (got.block_timecode != want.block_timecode)
				report("block_timecode", got.block_timecode, want.block_timecode);
			if (got.block_flags != want.block_flags)
				report("block_flags", got.block_flags, want.block_flags);
			if (got.payload_offset != want.payload_offset)
				report("payload_offset", got.payload_offset, want.payload_offset);
			if (got.payload_size != want.payload_size)
				report("payload_size", got.payload_size, want.payload_size);
			if (got.cluster_time != want.cluster_time)
				report("cluster_time", got.cluster_time, want.cluster_time);
			if (got.status != want.status) report("status", got.status, want.status);
			if (got.last_of_run != want.last_of_run)
				report("last_of_run", got.last_of_run, want.last_of_run);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] data_byte;
	logic end_of_buffer;
	logic out_valid;
	logic out_stall;
	logic [1:0] kind;
	logic [15:0] block_index;
	logic [31:0] track_number;
	logic [15:0] block_timecode;
	logic [7:0] block_flags;
	logic [31:0] payload_offset;
	logic [31:0] payload_size;
	logic [63:0] cluster_time;
	logic [2:0] status;
	logic last_of_run;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ClusterScoreboard sb;
	int cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int buffers_sent;
	logic [7:0] buffer_bytes[$];

	ebml_cluster_block_parser uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_buffer(end_of_buffer),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .block_index(block_index), .track_number(track_number),
		.block_timecode(block_timecode), .block_flags(block_flags),
		.payload_offset(payload_offset), .payload_size(payload_size),
		.cluster_time(cluster_time), .status(status), .last_of_run(last_of_run),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Cycle count and the run's time limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL ebml_cluster_block_parser");
			$finish;
		end
	end

	// Result side: check each transfer and stall at random.
	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind;
			got.block_index = block_index;
			got.track_number = track_number;
			got.block_timecode = block_timecode;
			got.block_flags = block_flags;
			got.payload_offset = payload_offset;
			got.payload_size = payload_size;
			got.cluster_time = cluster_time;
			got.status = status;
			got.last_of_run = last_of_run;
			sb.check_result(got);
		end
		out_stall <= arst_n && ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Send one byte; in_valid stays high for a following byte.
	task automatic send_byte(logic [7:0] b, logic eob);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b, eob);
	endtask

	task automatic send_buffer();
		foreach (buffer_bytes[i]) send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
		buffers_sent++;
	endtask

	// Hold off input until every expected result has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_blocks(logic [15:0] value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_MAX_BLOCKS);
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.block_limit = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic void push_vint(logic [63:0] v, int len);
		for (int i = len - 1; i >= 0; i--) begin
			if (i == len - 1) buffer_bytes.push_back((8'h80 >> (len - 1)) | 8'(v >> (8 * i)));
			else buffer_bytes.push_back(8'(v >> (8 * i)));
		end
	endfunction

	// Length of the shortest vint for v, sometimes padded.
	function automatic int vint_len(logic [63:0] v);
		int n;
		n = 1;
		while (n < 8 && v >= (64'd1 << (7 * n)) - 1) n++;
		if ($urandom_range(0, 3) == 0) n = $urandom_range(n, 8);
		return n;
	endfunction

	function automatic void push_random(int n);
		repeat (n) buffer_bytes.push_back(8'($urandom));
	endfunction

	// One child element appended to buffer_bytes.
	function automatic void push_child();
		int sel;
		int n;
		int hdr;
		int pay;
		logic [63:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 20 || (sel >= 70 && sel < 85)) begin
			// Timecode or a skipped integer, with an occasional bad size.
			if (sel < 20) buffer_bytes.push_back(TAG_TIMECODE[7:0]);
			else if ($urandom_range(0, 1)) buffer_bytes.push_back(TAG_POSITION[7:0]);
			else buffer_bytes.push_back(TAG_PREVSIZE[7:0]);
			if ($urandom_range(0, 19) == 0) n = $urandom_range(0, 1) ? 0 : 9;
			else n = $urandom_range(1, 8);
			push_vint(n, vint_len(n));
			push_random(n);
		end else if (sel < 55) begin
			// Simple block: track vint, timecode, flags, payload.
			buffer_bytes.push_back(TAG_SBLOCK[7:0]);
			n = $urandom_range(1, 3);
			v = {32'd0, $urandom} & ((64'd1 << (7 * n)) - 2);
			hdr = n + 3;
			pay = $urandom_range(0, 5);
			if ($urandom_range(0, 9) == 0) push_vint($urandom_range(0, hdr), 1);
			else push_vint(hdr + pay, vint_len(hdr + pay));
			push_vint(v, n);
			push_random(2 + 1 + pay);
		end else if (sel < 70) begin
			// Silent tracks or block group, skipped by length.
			if ($urandom_range(0, 1)) begin
				buffer_bytes.push_back(TAG_SILENT[15:8]);
				buffer_bytes.push_back(TAG_SILENT[7:0]);
			end else begin
				buffer_bytes.push_back(TAG_BGROUP[7:0]);
			end
			n = $urandom_range(0, 6);
			push_vint(n, vint_len(n));
			push_random(n);
		end else begin
			// Unknown tag, sometimes wider than four bytes.
			if ($urandom_range(0, 1)) buffer_bytes.push_back(8'hC0 | 8'($urandom_range(0, 63)));
			else begin
				buffer_bytes.push_back(8'h04);
				push_random(4);
			end
			push_random($urandom_range(0, 3));
		end
	endfunction

	// A buffer: mostly a well-formed cluster, with damage or noise now and then.
	function automatic void make_buffer();
		logic [7:0] body[$];
		int size;
		int sel;
		buffer_bytes.delete();
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			push_random($urandom_range(1, 6));
			return;
		end
		repeat ($urandom_range(0, 5)) push_child();
		body = buffer_bytes;
		buffer_bytes.delete();
		for (int i = 3; i >= 0; i--) buffer_bytes.push_back(TAG_CLUSTER[8*i +: 8]);
		size = body.size();
		if (sel < 20) size = size + $urandom_range(0, 4) - 2;
		if (size < 0) size = 0;
		if (sel == 20) begin
			buffer_bytes.push_back(8'h01);
			push_random(7);
		end else begin
			push_vint(size, vint_len(size));
		end
		foreach (body[i]) buffer_bytes.push_back(body[i]);
		if (sel < 30 && buffer_bytes.size() > 1)
			buffer_bytes[$urandom_range(0, buffer_bytes.size() - 1)] = 8'($urandom);
		if (sel >= 30 && sel < 38 && buffer_bytes.size() > 1)
			buffer_bytes = buffer_bytes[0:$urandom_range(0, buffer_bytes.size() - 2)];
		if (sel >= 38 && sel < 50) push_random($urandom_range(1, 3));
	endfunction

	initial begin
		logic [15:0] limits[5];
		int phase_items;
		sb = new();
		cycles = 0;
		buffers_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'd0;
		end_of_buffer <= 1'b0;
		out_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed buffers: malformed first byte, wrong cluster tag, empty cluster
		// with trailing bytes, oversized cluster length, and a timecode that ends
		// in the same byte as a truncated buffer.
		buffer_bytes = '{8'h00};
		send_buffer();
		buffer_bytes = '{8'hFF};
		send_buffer();
		buffer_bytes = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h80, 8'h55};
		send_buffer();
		buffer_bytes = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF};
		send_buffer();
		buffer_bytes = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h84, 8'hE7, 8'h81, 8'h05};
		send_buffer();

		// Random phases over block limits and idle patterns.
		limits = '{16'd0, 16'd1, 16'd3, 16'hFFFF, MaxBlocksReset};
		for (int p = 0; p < 8; p++) begin
			write_max_blocks(limits[p % 5]);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 49; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 49; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			phase_items = sb.bytes_taken + 225;
			while (sb.bytes_taken < phase_items) begin
				make_buffer();
				send_buffer();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("%0d bytes in %0d buffers sent, %0d results checked, %0d mismatches",
			sb.bytes_taken, buffers_sent, sb.results_seen, sb.errors);
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("PASS ebml_cluster_block_parser");
		end else begin
			$display("FAIL ebml_cluster_block_parser");
		end
		$finish;
	end

endmodule

// File: sim.f
src/ecbp_pkg.sv
src/ecbp_core.sv
src/ecbp_outq.sv
src/ebml_cluster_block_parser.sv
sim/tb_ebml_cluster_block_parser.sv
